FILE: hdl/tpaf_pkg.sv
// ----------------------------------------------------------------------------
// tpaf_pkg
// Shared types, codes and the firing delay table of the phase-angle firing
// controller.
// ----------------------------------------------------------------------------
package tpaf_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned OpW     = 2;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;
  localparam int unsigned FrameW  = 2;
  localparam int unsigned TableN  = 15;

  // event kinds
  localparam logic [OpW-1:0] OP_EDGE = 2'd0;
  localparam logic [OpW-1:0] OP_TICK = 2'd1;
  localparam logic [OpW-1:0] OP_BYTE = 2'd2;

  // frame receiver positions
  localparam logic [FrameW-1:0] FRAME_IDLE     = 2'd0;
  localparam logic [FrameW-1:0] FRAME_SETPOINT = 2'd1;
  localparam logic [FrameW-1:0] FRAME_MODE     = 2'd2;

  // register select (paddr bit 2)
  localparam logic REG_PULSE_RELOAD = 1'b0;
  localparam logic REG_START_BYTE   = 1'b1;

  localparam logic [DataW-1:0] PULSE_RELOAD_RST = 8'd242;
  localparam logic [DataW-1:0] START_BYTE_RST   = 8'hAA;
  localparam logic [DataW-1:0] DELAY_MAX        = 8'd252;

  localparam logic [DataW-1:0] MODE_ALTERNATE = 8'd0;
  localparam logic [DataW-1:0] MODE_FULL      = 8'd1;

  localparam logic [TableN-1:0][DataW-1:0] BOUND_TAB = {
    8'd230, 8'd220, 8'd210, 8'd200, 8'd190, 8'd180, 8'd170, 8'd160,
    8'd140, 8'd115, 8'd78,  8'd69,  8'd60,  8'd50,  8'd40
  };
  localparam logic [TableN-1:0][DataW-1:0] DELAY_TAB = {
    8'd252, 8'd248, 8'd242, 8'd235, 8'd226, 8'd218, 8'd210, 8'd203,
    8'd195, 8'd187, 8'd180, 8'd172, 8'd164, 8'd156, 8'd149
  };

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] rx_byte;
  } event_t;

  typedef struct packed {
    logic             gate_level;
    logic             timer_active;
    logic [DataW-1:0] timer_count;
    logic [DataW-1:0] firing_delay;
    logic [DataW-1:0] setpoint;
    logic [DataW-1:0] mode;
    logic             frame_done;
  } result_t;

  function automatic logic [DataW-1:0] delay_of(input logic [DataW-1:0] sp);
    logic [DataW-1:0] d;
    d = DELAY_MAX;
    for (int i = TableN - 1; i >= 0; i--) begin
      if (sp <= BOUND_TAB[i]) begin
        d = DELAY_TAB[i];
      end
    end
    return d;
  endfunction

endpackage

FILE: hdl/tpaf_if.sv
// ----------------------------------------------------------------------------
// tpaf_in_if / tpaf_out_if
// Valid/ready channels for events and results of the firing controller.
// ----------------------------------------------------------------------------
interface tpaf_in_if;
  logic                        valid;
  logic                        ready;
  logic [tpaf_pkg::OpW-1:0]    op;
  logic [tpaf_pkg::DataW-1:0]  rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface tpaf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        gate_level;
  logic                        timer_active;
  logic [tpaf_pkg::DataW-1:0]  timer_count;
  logic [tpaf_pkg::DataW-1:0]  firing_delay;
  logic [tpaf_pkg::DataW-1:0]  setpoint;
  logic [tpaf_pkg::DataW-1:0]  mode;
  logic                        frame_done;

  modport source (
    output valid, output gate_level, output timer_active, output timer_count,
    output firing_delay, output setpoint, output mode, output frame_done,
    input ready
  );
  modport sink (
    input valid, input gate_level, input timer_active, input timer_count,
    input firing_delay, input setpoint, input mode, input frame_done,
    output ready
  );
endinterface

FILE: hdl/tpaf_core.sv
// ----------------------------------------------------------------------------
// tpaf_core
// Controller state and its single-pass update for one event: zero-cross
// phase, tick counter with gate pulse, and serial frame receiver.
// ----------------------------------------------------------------------------
module tpaf_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       evt_valid_i,
  input  tpaf_pkg::event_t           evt_i,
  input  logic [tpaf_pkg::DataW-1:0] pulse_reload_i,
  input  logic [tpaf_pkg::DataW-1:0] start_byte_i,
  output tpaf_pkg::result_t          res_o
);
  import tpaf_pkg::*;

  logic              zc_phase_q, zc_phase_d;
  logic              pulse_phase_q, pulse_phase_d;
  logic              timer_on_q, timer_on_d;
  logic              gate_q, gate_d;
  logic [DataW-1:0]  count_q, count_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [DataW-1:0]  held_sp_q, held_sp_d;
  logic [DataW-1:0]  setpoint_q, setpoint_d;
  logic [DataW-1:0]  mode_q, mode_d;
  logic [DataW-1:0]  edge_delay;
  logic [DataW-1:0]  count_inc;
  logic              done;

  assign edge_delay = delay_of(setpoint_q);
  assign count_inc  = count_q + 8'd1;

  always_comb begin
    zc_phase_d    = zc_phase_q;
    pulse_phase_d = pulse_phase_q;
    timer_on_d    = timer_on_q;
    gate_d        = gate_q;
    count_d       = count_q;
    frame_d       = frame_q;
    held_sp_d     = held_sp_q;
    setpoint_d    = setpoint_q;
    mode_d        = mode_q;
    done          = 1'b0;
    case (evt_i.op)
      OP_EDGE: begin
        if (mode_q == MODE_FULL) begin
          gate_d     = 1'b1;
          count_d    = edge_delay;
          timer_on_d = 1'b1;
          zc_phase_d = ~zc_phase_q;
        end else if (mode_q == MODE_ALTERNATE) begin
          gate_d = 1'b1;
          if (!zc_phase_q) begin
            count_d    = edge_delay;
            timer_on_d = 1'b1;
            zc_phase_d = 1'b1;
          end else begin
            count_d    = '0;
            timer_on_d = 1'b0;
            zc_phase_d = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (timer_on_q) begin
          count_d = count_inc;
          if (count_inc == '0) begin
            if (!pulse_phase_q) begin
              gate_d        = 1'b0;
              count_d       = pulse_reload_i;
              timer_on_d    = 1'b1;
              pulse_phase_d = 1'b1;
            end else begin
              gate_d        = 1'b1;
              count_d       = '0;
              timer_on_d    = 1'b0;
              pulse_phase_d = 1'b0;
            end
          end
        end
      end
      OP_BYTE: begin
        if (frame_q == FRAME_IDLE) begin
          if (evt_i.rx_byte == start_byte_i) begin
            frame_d = FRAME_SETPOINT;
          end
        end else if (frame_q == FRAME_SETPOINT) begin
          held_sp_d = evt_i.rx_byte;
          frame_d   = FRAME_MODE;
        end else begin
          setpoint_d = held_sp_q;
          mode_d     = evt_i.rx_byte;
          frame_d    = FRAME_IDLE;
          done       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zc_phase_q    <= 1'b0;
      pulse_phase_q <= 1'b0;
      timer_on_q    <= 1'b1;
      gate_q        <= 1'b1;
      count_q       <= '0;
      frame_q       <= FRAME_IDLE;
      setpoint_q    <= '0;
      mode_q        <= '0;
    end else if (evt_valid_i) begin
      zc_phase_q    <= zc_phase_d;
      pulse_phase_q <= pulse_phase_d;
      timer_on_q    <= timer_on_d;
      gate_q        <= gate_d;
      count_q       <= count_d;
      frame_q       <= frame_d;
      setpoint_q    <= setpoint_d;
      mode_q        <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_valid_i) begin
      held_sp_q <= held_sp_d;
    end
  end

  always_comb begin
    res_o.gate_level   = gate_d;
    res_o.timer_active = timer_on_d;
    res_o.timer_count  = count_d;
    res_o.firing_delay = delay_of(setpoint_d);
    res_o.setpoint     = setpoint_d;
    res_o.mode         = mode_d;
    res_o.frame_done   = done;
  end

endmodule

FILE: hdl/triac_phase_angle_firing.sv
// ----------------------------------------------------------------------------
// triac_phase_angle_firing
// TRIAC phase-angle firing controller with APB register port.
// ----------------------------------------------------------------------------
// Every event (zero-cross edge, timer tick or serial byte) yields exactly one
// result showing the controller state after it. Events pass an input register,
// one pass of update logic and an output register: one event is taken every
// cycle while the output side is not stalled, and its result is valid at the
// output once it has passed both registers. While a result waits the input
// register still takes one more event.
// Registers: pulse_reload at 0x0, start_byte at 0x4; write them only
// while no event is in flight.
module triac_phase_angle_firing (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tpaf_in_if.sink                     in_i,
  tpaf_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpaf_pkg::PaddrW-1:0] paddr,
  input  logic [tpaf_pkg::PdataW-1:0] pwdata,
  output logic [tpaf_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  import tpaf_pkg::*;

  logic [DataW-1:0] pulse_reload_q;
  logic [DataW-1:0] start_byte_q;
  logic             cfg_wr;

  logic             in_valid_q;
  event_t           in_evt_q;
  logic             out_valid_q;
  result_t          out_res_q;
  result_t          core_res;
  logic             out_free;
  logic             fire;
  logic             in_take;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_reload_q <= PULSE_RELOAD_RST;
      start_byte_q   <= START_BYTE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_PULSE_RELOAD: pulse_reload_q <= pwdata[DataW-1:0];
        REG_START_BYTE:   start_byte_q   <= pwdata[DataW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_PULSE_RELOAD: prdata[DataW-1:0] = pulse_reload_q;
      REG_START_BYTE:   prdata[DataW-1:0] = start_byte_q;
      default: begin
      end
    endcase
  end

  // handshake
  assign out_free   = ~out_valid_q | out_o.ready;
  assign fire       = in_valid_q & out_free;
  assign in_i.ready = ~in_valid_q | out_free;
  assign in_take    = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_evt_q.op      <= in_i.op;
      in_evt_q.rx_byte <= in_i.rx_byte;
    end
    if (fire) begin
      out_res_q <= core_res;
    end
  end

  tpaf_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .evt_valid_i    (fire),
    .evt_i          (in_evt_q),
    .pulse_reload_i (pulse_reload_q),
    .start_byte_i   (start_byte_q),
    .res_o          (core_res)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.gate_level   = out_res_q.gate_level;
  assign out_o.timer_active = out_res_q.timer_active;
  assign out_o.timer_count  = out_res_q.timer_count;
  assign out_o.firing_delay = out_res_q.firing_delay;
  assign out_o.setpoint     = out_res_q.setpoint;
  assign out_o.mode         = out_res_q.mode;
  assign out_o.frame_done   = out_res_q.frame_done;

endmodule

FILE: tb/triac_phase_angle_firing_tb.sv
// ----------------------------------------------------------------------------
// triac_phase_angle_firing_tb
// Self-checking bench for the phase-angle firing controller. A directed table
// walks reset values, counter wraps, both firing modes, other modes and frame
// corner cases, then random phases of frames, edges and tick runs follow
// under several register settings. Each result is checked against the table or a
// local controller model, with random idling on both channels outside the quiet phase.
// ----------------------------------------------------------------------------
module triac_phase_angle_firing_tb;
  import tpaf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OpW-1:0] OP_NONE = 2'd3;
  localparam int unsigned    DirN    = 27;
  localparam int unsigned    PhaseN  = 200;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] data;
    logic [8:0]       reps;
    logic             chk;
    result_t          want;
  } step_row_t;

  localparam result_t NO_RESULT = '0;

  localparam step_row_t DIRECTED_STEPS [DirN] = '{
    '{OP_NONE, 8'hFF, 9'd1,   1'b1, '{1'b1, 1'b1, 8'd0,   8'd149, 8'd0,   8'd0, 1'b0}},
    '{OP_TICK, 8'h00, 9'd1,   1'b1, '{1'b1, 1'b1, 8'd1,   8'd149, 8'd0,   8'd0, 1'b0}},
    '{OP_BYTE, 8'h00, 9'd1,   1'b1, '{1'b1, 1'b1, 8'd1,   8'd149, 8'd0,   8'd0, 1'b0}},
    '{OP_TICK, 8'h00, 9'd254, 1'b0, NO_RESULT},
    '{OP_TICK, 8'h00, 9'd1,   1'b1, '{1'b0, 1'b1, 8'd242, 8'd149, 8'd0,   8'd0, 1'b0}},
    '{OP_TICK, 8'h00, 9'd13,  1'b0, NO_RESULT},
    '{OP_TICK, 8'h00, 9'd1,   1'b1, '{1'b1, 1'b0, 8'd0,   8'd149, 8'd0,   8'd0, 1'b0}},
    '{OP_TICK, 8'h00, 9'd1,   1'b1, '{1'b1, 1'b0, 8'd0,   8'd149, 8'd0,   8'd0, 1'b0}},
    '{OP_EDGE, 8'h00, 9'd1,   1'b1, '{1'b1, 1'b1, 8'd149, 8'd149, 8'd0,   8'd0, 1'b0}},
    '{OP_EDGE, 8'h00, 9'd1,   1'b1, '{1'b1, 1'b0, 8'd0,   8'd149, 8'd0,   8'd0, 1'b0}},
    '{OP_BYTE, 8'hAA, 9'd1,   1'b0, NO_RESULT},
    '{OP_BYTE, 8'hAA, 9'd1,   1'b0, NO_RESULT},
    '{OP_BYTE, 8'h01, 9'd1,   1'b1, '{1'b1, 1'b0, 8'd0,   8'd210, 8'd170, 8'd1, 1'b1}},
    '{OP_EDGE, 8'h00, 9'd1,   1'b1, '{1'b1, 1'b1, 8'd210, 8'd210, 8'd170, 8'd1, 1'b0}},
    '{OP_TICK, 8'h00, 9'd46,  1'b0, NO_RESULT},
    '{OP_BYTE, 8'hAA, 9'd1,   1'b0, NO_RESULT},
    '{OP_BYTE, 8'hFF, 9'd1,   1'b0, NO_RESULT},
    '{OP_BYTE, 8'h00, 9'd1,   1'b1, '{1'b0, 1'b1, 8'd242, 8'd252, 8'd255, 8'd0, 1'b1}},
    '{OP_EDGE, 8'h00, 9'd1,   1'b1, '{1'b1, 1'b0, 8'd0,   8'd252, 8'd255, 8'd0, 1'b0}},
    '{OP_BYTE, 8'hAA, 9'd1,   1'b0, NO_RESULT},
    '{OP_BYTE, 8'd41, 9'd1,   1'b0, NO_RESULT},
    '{OP_BYTE, 8'h02, 9'd1,   1'b1, '{1'b1, 1'b0, 8'd0,   8'd156, 8'd41,  8'd2, 1'b1}},
    '{OP_EDGE, 8'h00, 9'd1,   1'b1, '{1'b1, 1'b0, 8'd0,   8'd156, 8'd41,  8'd2, 1'b0}},
    '{OP_BYTE, 8'hAA, 9'd1,   1'b0, NO_RESULT},
    '{OP_BYTE, 8'd230, 9'd1,  1'b0, NO_RESULT},
    '{OP_BYTE, 8'h01, 9'd1,   1'b1, '{1'b1, 1'b0, 8'd0,   8'd252, 8'd230, 8'd1, 1'b1}},
    '{OP_EDGE, 8'h00, 9'd1,   1'b1, '{1'b1, 1'b1, 8'd252, 8'd252, 8'd230, 8'd1, 1'b0}}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  tpaf_in_if  ev_if ();
  tpaf_out_if res_if ();

  triac_phase_angle_firing dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (ev_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // controller model state
  logic [DataW-1:0]  pulse_width_cfg;
  logic [DataW-1:0]  start_byte_cfg;
  logic              zc_phase;
  logic              pulse_phase;
  logic              tick_run;
  logic [DataW-1:0]  tick_cnt;
  logic              gate_pin;
  logic [FrameW-1:0] frame_pos;
  logic [DataW-1:0]  held_setpoint;
  logic [DataW-1:0]  setpoint_val;
  logic [DataW-1:0]  mode_val;

  result_t pending_results [$];
  int      err_count;
  int      events_sent;
  bit      quiet;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [DataW-1:0] delay_for_setpoint(input logic [DataW-1:0] s);
    if (s <= 8'd40) return 8'd149;
    else if (s <= 8'd50) return 8'd156;
    else if (s <= 8'd60) return 8'd164;
    else if (s <= 8'd69) return 8'd172;
    else if (s <= 8'd78) return 8'd180;
    else if (s <= 8'd115) return 8'd187;
    else if (s <= 8'd140) return 8'd195;
    else if (s <= 8'd160) return 8'd203;
    else if (s <= 8'd170) return 8'd210;
    else if (s <= 8'd180) return 8'd218;
    else if (s <= 8'd190) return 8'd226;
    else if (s <= 8'd200) return 8'd235;
    else if (s <= 8'd210) return 8'd242;
    else if (s <= 8'd220) return 8'd248;
    return 8'd252;
  endfunction

  function automatic result_t advance_controller(input logic [OpW-1:0] op,
                                                 input logic [DataW-1:0] b);
    result_t r;
    logic    done;
    done = 1'b0;
    case (op)
      OP_EDGE: begin
        if (mode_val == MODE_FULL) begin
          gate_pin = 1'b1;
          tick_cnt = delay_for_setpoint(setpoint_val);
          tick_run = 1'b1;
          zc_phase = ~zc_phase;
        end else if (mode_val == MODE_ALTERNATE) begin
          gate_pin = 1'b1;
          if (!zc_phase) begin
            tick_cnt = delay_for_setpoint(setpoint_val);
            tick_run = 1'b1;
            zc_phase = 1'b1;
          end else begin
            tick_cnt = '0;
            tick_run = 1'b0;
            zc_phase = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (tick_run) begin
          tick_cnt = tick_cnt + 8'd1;
          if (tick_cnt == '0) begin
            if (!pulse_phase) begin
              gate_pin    = 1'b0;
              tick_cnt    = pulse_width_cfg;
              pulse_phase = 1'b1;
            end else begin
              gate_pin    = 1'b1;
              tick_run    = 1'b0;
              pulse_phase = 1'b0;
            end
          end
        end
      end
      OP_BYTE: begin
        case (frame_pos)
          FRAME_IDLE: begin
            if (b == start_byte_cfg) frame_pos = FRAME_SETPOINT;
          end
          FRAME_SETPOINT: begin
            held_setpoint = b;
            frame_pos     = FRAME_MODE;
          end
          default: begin
            setpoint_val = held_setpoint;
            mode_val     = b;
            frame_pos    = FRAME_IDLE;
            done         = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
    r.gate_level   = gate_pin;
    r.timer_active = tick_run;
    r.timer_count  = tick_cnt;
    r.firing_delay = delay_for_setpoint(setpoint_val);
    r.setpoint     = setpoint_val;
    r.mode         = mode_val;
    r.frame_done   = done;
    return r;
  endfunction

  // one event transfer, with an occasional idle gap before it
  task automatic send_event(input logic [OpW-1:0] op, input logic [DataW-1:0] b,
                            input logic chk, input result_t want);
    result_t predicted;
    if (!quiet && $urandom_range(0, 99) < 7) begin
      ev_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    ev_if.valid   <= 1'b1;
    ev_if.op      <= op;
    ev_if.rx_byte <= b;
    do @(posedge clk_i); while (ev_if.ready !== 1'b1);
    predicted = advance_controller(op, b);
    pending_results.push_back(chk ? want : predicted);
    events_sent++;
  endtask

  task automatic send_plain(input logic [OpW-1:0] op, input logic [DataW-1:0] b);
    send_event(op, b, 1'b0, NO_RESULT);
  endtask

  task automatic wait_idle();
    ev_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [DataW-1:0] val);
    logic [PdataW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= PdataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[DataW-1:0] !== val)
      report_mismatch($sformatf("reg %0d read %0h, wrote %0h", sel, rd, val));
    if (sel == REG_PULSE_RELOAD) pulse_width_cfg = val;
    else start_byte_cfg = val;
  endtask

  task automatic run_random(input int unsigned n_events);
    int unsigned      target;
    int unsigned      k;
    logic [DataW-1:0] m;
    target = events_sent + n_events;
    while (events_sent < target) begin
      k = $urandom_range(0, 99);
      if (k < 14) begin
        send_plain(OP_BYTE, start_byte_cfg);
        send_plain(OP_BYTE, DataW'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) >= 8) begin
          k = $urandom_range(0, 99);
          if (k < 45) m = MODE_ALTERNATE;
          else if (k < 90) m = MODE_FULL;
          else m = DataW'($urandom_range(0, 255));
          send_plain(OP_BYTE, m);
        end
      end else if (k < 24) begin
        send_plain(OP_EDGE, DataW'($urandom_range(0, 255)));
      end else if (k < 28) begin
        send_plain(($urandom_range(0, 1) != 0) ? OP_NONE : OP_BYTE,
                   DataW'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 40))
          send_plain(OP_TICK, DataW'($urandom_range(0, 255)));
      end
    end
  endtask

  // result checking and output stalls
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got = '{res_if.gate_level, res_if.timer_active, res_if.timer_count,
              res_if.firing_delay, res_if.setpoint, res_if.mode, res_if.frame_done};
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with none outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got.gate_level !== want.gate_level)
          report_mismatch($sformatf("gate_level %0h exp %0h", got.gate_level,
                                    want.gate_level));
        if (got.timer_active !== want.timer_active)
          report_mismatch($sformatf("timer_active %0h exp %0h", got.timer_active,
                                    want.timer_active));
        if (got.timer_count !== want.timer_count)
          report_mismatch($sformatf("timer_count %0d exp %0d", got.timer_count,
                                    want.timer_count));
        if (got.firing_delay !== want.firing_delay)
          report_mismatch($sformatf("firing_delay %0d exp %0d", got.firing_delay,
                                    want.firing_delay));
        if (got.setpoint !== want.setpoint)
          report_mismatch($sformatf("setpoint %0d exp %0d", got.setpoint,
                                    want.setpoint));
        if (got.mode !== want.mode)
          report_mismatch($sformatf("mode %0d exp %0d", got.mode, want.mode));
        if (got.frame_done !== want.frame_done)
          report_mismatch($sformatf("frame_done %0h exp %0h", got.frame_done,
                                    want.frame_done));
      end
    end
    res_if.ready <= quiet || ($urandom_range(0, 99) >= 7);
  end

  initial begin
    #2000000;
    $display("triac_phase_angle_firing_tb: done, errors");
    $finish;
  end

  initial begin
    step_row_t row;
    rst_ni        <= 1'b0;
    ev_if.valid   <= 1'b0;
    ev_if.op      <= OP_EDGE;
    ev_if.rx_byte <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    err_count       = 0;
    events_sent     = 0;
    quiet           = 1'b0;
    pulse_width_cfg = PULSE_RELOAD_RST;
    start_byte_cfg  = START_BYTE_RST;
    zc_phase        = 1'b0;
    pulse_phase     = 1'b0;
    tick_run        = 1'b1;
    tick_cnt        = '0;
    gate_pin        = 1'b1;
    frame_pos       = FRAME_IDLE;
    held_setpoint   = '0;
    setpoint_val    = '0;
    mode_val        = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirN; i++) begin
      row = DIRECTED_STEPS[i];
      for (int j = 1; j <= int'(row.reps); j++)
        send_event(row.op, row.data, row.chk && (j == int'(row.reps)), row.want);
    end
    wait_idle();

    write_reg(REG_PULSE_RELOAD, 8'd255);
    write_reg(REG_START_BYTE, START_BYTE_RST);
    run_random(PhaseN);
    wait_idle();

    // no idling on either side in this phase
    quiet = 1'b1;
    write_reg(REG_PULSE_RELOAD, 8'd0);
    write_reg(REG_START_BYTE, 8'h00);
    run_random(PhaseN);
    wait_idle();
    quiet = 1'b0;

    write_reg(REG_PULSE_RELOAD, DataW'($urandom_range(0, 255)));
    write_reg(REG_START_BYTE, 8'hFF);
    run_random(PhaseN);
    wait_idle();

    write_reg(REG_PULSE_RELOAD, DataW'($urandom_range(0, 255)));
    write_reg(REG_START_BYTE, DataW'($urandom_range(0, 255)));
    run_random(PhaseN);
    wait_idle();

    if (err_count == 0) begin
      $display("triac_phase_angle_firing_tb: done, clean");
    end else begin
      $display("triac_phase_angle_firing_tb: done, errors");
    end
    $finish;
  end

endmodule
